// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is asserted
`define CBCT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// clocked property that must also hold while reset is asserted
`define CBCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/cbct_pkg.sv
// types, widths and field offsets for the circle/box collision test
`timescale 1ns / 1ps
package cbct_pkg;

  localparam int COORD_BITS = 16;

  localparam int KIND_W  = 2;
  localparam int LEN_W   = COORD_BITS - 1;  // radius, width, height
  localparam int DC_W    = COORD_BITS + 1;  // doubled coordinate
  localparam int RAD_W   = COORD_BITS;      // doubled radius
  localparam int LIM_W   = COORD_BITS + 1;  // sum of two doubled radii
  localparam int EDGE_W  = COORD_BITS + 2;  // box edge, centre difference
  localparam int BAND_W  = COORD_BITS + 3;  // edge widened by a radius
  localparam int OP_W    = COORD_BITS + 2;  // distance operand
  localparam int SQ_W    = 2 * OP_W;        // square and sum of squares

  localparam int NUM_STAGES = 5;

  // input stream layout
  localparam int IN_TUSER_W = 2 * KIND_W;
  localparam int SHAPE_BITS = 2 * COORD_BITS + 3 * LEN_W;
  localparam int IN_BITS    = 2 * SHAPE_BITS;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int A_OFS      = 0;
  localparam int B_OFS      = SHAPE_BITS;
  localparam int X_OFS      = 0;
  localparam int Y_OFS      = COORD_BITS;
  localparam int R_OFS      = 2 * COORD_BITS;
  localparam int W_OFS      = 2 * COORD_BITS + LEN_W;
  localparam int H_OFS      = 2 * COORD_BITS + 2 * LEN_W;

  localparam int OUT_TDATA_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE   = 2'd0,
    KIND_CIRCLE = 2'd1,
    KIND_BOX    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_CC,
    MODE_CB,
    MODE_BB
  } mode_e;

  // last member sits in the lowest bits, so x lands at bit 0 of the slice
  typedef struct packed {
    logic [LEN_W-1:0]             height;
    logic [LEN_W-1:0]             width;
    logic [LEN_W-1:0]             radius;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } shape_t;

  // first stage: differences and box edges
  typedef struct packed {
    mode_e                    mode;
    logic                     bb_hit;
    logic signed [OP_W-1:0]   dx;
    logic signed [OP_W-1:0]   dy;
    logic [LIM_W-1:0]         lim;
    logic signed [DC_W-1:0]   cx;
    logic signed [DC_W-1:0]   cy;
    logic [RAD_W-1:0]         r;
    logic signed [EDGE_W-1:0] left;
    logic signed [EDGE_W-1:0] right;
    logic signed [EDGE_W-1:0] top;
    logic signed [EDGE_W-1:0] bottom;
  } setup_t;

  // second stage: band and corner region flags
  typedef struct packed {
    setup_t s;
    logic   band;
    logic   lt_l;
    logic   gt_r;
    logic   lt_t;
    logic   gt_b;
  } region_t;

  // third stage: operands of the distance compare
  typedef struct packed {
    logic                   need_dist;
    logic                   direct;
    logic signed [OP_W-1:0] u;
    logic signed [OP_W-1:0] v;
    logic [LIM_W-1:0]       lim;
  } operand_t;

  // fourth stage: squares
  typedef struct packed {
    logic                 need_dist;
    logic                 direct;
    logic [SQ_W-1:0]      sq_u;
    logic [SQ_W-1:0]      sq_v;
    logic [2*LIM_W-1:0]   sq_lim;
  } square_t;

endpackage

// File: src/cbct_setup.sv
// stage one: case decode, doubled coordinates, box edges and box/box test
`timescale 1ns / 1ps
module cbct_setup import cbct_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [KIND_W-1:0]   kind_a_i,
  input  logic [KIND_W-1:0]   kind_b_i,
  input  shape_t              a_i,
  input  shape_t              b_i,
  output setup_t              s1_o
);

  logic signed [DC_W-1:0]   ax2, ay2, bx2, by2;
  logic [RAD_W-1:0]         ar2, br2;
  logic signed [EDGE_W-1:0] aw_e, ah_e, bw_e, bh_e;
  logic signed [EDGE_W-1:0] a_lo_x, a_hi_x, a_lo_y, a_hi_y;
  logic signed [EDGE_W-1:0] b_lo_x, b_hi_x, b_lo_y, b_hi_y;
  logic                     swap;
  setup_t                   s1_d, s1_q;

  // doubling keeps the box half sizes exact
  assign ax2 = {a_i.x, 1'b0};
  assign ay2 = {a_i.y, 1'b0};
  assign bx2 = {b_i.x, 1'b0};
  assign by2 = {b_i.y, 1'b0};
  assign ar2 = {a_i.radius, 1'b0};
  assign br2 = {b_i.radius, 1'b0};
  assign aw_e = EDGE_W'(a_i.width);
  assign ah_e = EDGE_W'(a_i.height);
  assign bw_e = EDGE_W'(b_i.width);
  assign bh_e = EDGE_W'(b_i.height);

  assign a_lo_x = EDGE_W'(ax2) - aw_e;
  assign a_hi_x = EDGE_W'(ax2) + aw_e;
  assign a_lo_y = EDGE_W'(ay2) - ah_e;
  assign a_hi_y = EDGE_W'(ay2) + ah_e;
  assign b_lo_x = EDGE_W'(bx2) - bw_e;
  assign b_hi_x = EDGE_W'(bx2) + bw_e;
  assign b_lo_y = EDGE_W'(by2) - bh_e;
  assign b_hi_y = EDGE_W'(by2) + bh_e;

  always_comb begin
    s1_d.mode = MODE_NONE;
    swap      = 1'b0;
    if (kind_a_i == KIND_CIRCLE && kind_b_i == KIND_CIRCLE) begin
      s1_d.mode = MODE_CC;
    end else if (kind_a_i == KIND_CIRCLE && kind_b_i == KIND_BOX) begin
      s1_d.mode = MODE_CB;
    end else if (kind_a_i == KIND_BOX && kind_b_i == KIND_CIRCLE) begin
      s1_d.mode = MODE_CB;
      swap      = 1'b1;
    end else if (kind_a_i == KIND_BOX && kind_b_i == KIND_BOX) begin
      s1_d.mode = MODE_BB;
    end

    s1_d.bb_hit = (b_lo_x < a_hi_x) && (a_lo_x < b_hi_x) &&
                  (b_lo_y < a_hi_y) && (a_lo_y < b_hi_y);
    s1_d.dx  = EDGE_W'(ax2) - EDGE_W'(bx2);
    s1_d.dy  = EDGE_W'(ay2) - EDGE_W'(by2);
    s1_d.lim = LIM_W'(ar2) + LIM_W'(br2);

    // circle in cx/cy/r, box as edges, whichever side each came in on
    if (swap) begin
      s1_d.cx     = bx2;
      s1_d.cy     = by2;
      s1_d.r      = br2;
      s1_d.left   = a_lo_x;
      s1_d.right  = a_hi_x;
      s1_d.top    = a_lo_y;
      s1_d.bottom = a_hi_y;
    end else begin
      s1_d.cx     = ax2;
      s1_d.cy     = ay2;
      s1_d.r      = ar2;
      s1_d.left   = b_lo_x;
      s1_d.right  = b_hi_x;
      s1_d.top    = b_lo_y;
      s1_d.bottom = b_hi_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

// File: src/cbct_region.sv
// stages two and three: widened box band, corner region and distance operands
`timescale 1ns / 1ps
module cbct_region import cbct_pkg::*; (
  input  logic     clk_i,
  input  logic     en2_i,
  input  logic     en3_i,
  input  setup_t   s1_i,
  output operand_t s3_o
);

  logic signed [BAND_W-1:0]   r_b, cx_b, cy_b;
  logic signed [BAND_W-1:0]   lo_x, hi_x, lo_y, hi_y;
  logic signed [EDGE_W-1:0]   cx_e, cy_e;
  region_t                    s2_d, s2_q;
  logic signed [EDGE_W-1:0]   ex, ey;
  logic signed [EDGE_W:0]     ux, vy;
  logic                       corner;
  operand_t                   s3_d, s3_q;

  // stage two
  assign r_b  = BAND_W'(s1_i.r);
  assign cx_b = BAND_W'(s1_i.cx);
  assign cy_b = BAND_W'(s1_i.cy);
  assign lo_x = BAND_W'(s1_i.left) - r_b;
  assign hi_x = BAND_W'(s1_i.right) + r_b;
  assign lo_y = BAND_W'(s1_i.top) - r_b;
  assign hi_y = BAND_W'(s1_i.bottom) + r_b;
  assign cx_e = EDGE_W'(s1_i.cx);
  assign cy_e = EDGE_W'(s1_i.cy);

  always_comb begin
    s2_d.s    = s1_i;
    s2_d.band = (cx_b > lo_x) && (cx_b < hi_x) && (cy_b > lo_y) && (cy_b < hi_y);
    s2_d.lt_l = cx_e < s1_i.left;
    s2_d.gt_r = cx_e > s1_i.right;
    s2_d.lt_t = cy_e < s1_i.top;
    s2_d.gt_b = cy_e > s1_i.bottom;
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      s2_q <= s2_d;
    end
  end

  // stage three: nearest corner and the operands
  assign ex = s2_q.lt_l ? s2_q.s.left : s2_q.s.right;
  assign ey = s2_q.lt_t ? s2_q.s.top  : s2_q.s.bottom;
  assign ux = (EDGE_W + 1)'(s2_q.s.cx) - (EDGE_W + 1)'(ex);
  assign vy = (EDGE_W + 1)'(s2_q.s.cy) - (EDGE_W + 1)'(ey);
  assign corner = (s2_q.lt_l || s2_q.gt_r) && (s2_q.lt_t || s2_q.gt_b);

  always_comb begin
    s3_d.need_dist = 1'b0;
    s3_d.direct    = 1'b0;
    s3_d.u         = s2_q.s.dx;
    s3_d.v         = s2_q.s.dy;
    s3_d.lim       = s2_q.s.lim;
    unique case (s2_q.s.mode)
      MODE_CC: begin
        s3_d.need_dist = 1'b1;
      end
      MODE_CB: begin
        // inside the band the corner offset is below the radius, so it fits
        s3_d.need_dist = s2_q.band && corner;
        s3_d.direct    = s2_q.band && !corner;
        s3_d.u         = ux[OP_W-1:0];
        s3_d.v         = vy[OP_W-1:0];
        s3_d.lim       = LIM_W'(s2_q.s.r);
      end
      MODE_BB: begin
        s3_d.direct = s2_q.s.bb_hit;
      end
      MODE_NONE: begin
        s3_d.direct = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      s3_q <= s3_d;
    end
  end

  assign s3_o = s3_q;

endmodule

// File: src/cbct_distance.sv
// stages four and five: squares, then sum of squares against the squared limit
`timescale 1ns / 1ps
module cbct_distance import cbct_pkg::*; (
  input  logic     clk_i,
  input  logic     en4_i,
  input  logic     en5_i,
  input  operand_t s3_i,
  output logic     hit_o
);

  logic signed [SQ_W-1:0] prod_u, prod_v;
  square_t                s4_d, s4_q;
  logic [SQ_W-1:0]        sum_sq;
  logic                   hit_d, hit_q;

  assign prod_u = s3_i.u * s3_i.u;
  assign prod_v = s3_i.v * s3_i.v;

  always_comb begin
    s4_d.need_dist = s3_i.need_dist;
    s4_d.direct    = s3_i.direct;
    s4_d.sq_u      = prod_u;
    s4_d.sq_v      = prod_v;
    s4_d.sq_lim    = s3_i.lim * s3_i.lim;
  end

  always_ff @(posedge clk_i) begin
    if (en4_i) begin
      s4_q <= s4_d;
    end
  end

  // squares are never negative and their sum stays below 2^(SQ_W-1)
  assign sum_sq = s4_q.sq_u + s4_q.sq_v;
  assign hit_d  = s4_q.need_dist ? (sum_sq < SQ_W'(s4_q.sq_lim)) : s4_q.direct;

  always_ff @(posedge clk_i) begin
    if (en5_i) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

// File: src/circle_box_collision_test.sv
// top level of the circle/box collision test pipeline
//
// one request on the input stream carries two shapes: tuser holds the two
// kind codes (none, circle, box; code 3 counts as none), tdata the centres
// in signed Q12.4 and the radii and box sizes in unsigned Q11.4. each
// request yields one response whose tdata bit 0 is the hit flag.
// the path is five register stages: case decode and edges, band and corner
// flags, distance operands, squares, final compare. the last stage is the
// output register. one request per cycle is taken while the input is ready.
// every stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and the input stays ready while
// a finished response waits, as long as some stage is empty. a stalled
// output holds its response and the stages behind it fill up; nothing is
// dropped or repeated. reset clears all valid bits; no state links requests.
`timescale 1ns / 1ps
module circle_box_collision_test import cbct_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // from bit 0: a_x, a_y, a_radius, a_width, a_height,
  //             b_x, b_y, b_radius, b_width, b_height, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // from bit 0: kind_a, kind_b
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // from bit 0: hit, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic [NUM_STAGES-1:0] valid_d, valid_q;
  logic [NUM_STAGES-1:0] en;
  shape_t                shape_a, shape_b;
  setup_t                s1;
  operand_t              s3;
  logic                  hit;

  assign shape_a = s_axis_tdata_i[A_OFS +: SHAPE_BITS];
  assign shape_b = s_axis_tdata_i[B_OFS +: SHAPE_BITS];

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || m_axis_tready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d[0] = en[0] ? s_axis_tvalid_i : valid_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  cbct_setup u_setup (
    .clk_i    (clk_i),
    .en_i     (en[0]),
    .kind_a_i (s_axis_tuser_i[0 +: KIND_W]),
    .kind_b_i (s_axis_tuser_i[KIND_W +: KIND_W]),
    .a_i      (shape_a),
    .b_i      (shape_b),
    .s1_o     (s1)
  );

  cbct_region u_region (
    .clk_i (clk_i),
    .en2_i (en[1]),
    .en3_i (en[2]),
    .s1_i  (s1),
    .s3_o  (s3)
  );

  cbct_distance u_distance (
    .clk_i (clk_i),
    .en4_i (en[3]),
    .en5_i (en[4]),
    .s3_i  (s3),
    .hit_o (hit)
  );

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = valid_q[NUM_STAGES-1];
  assign m_axis_tdata_o  = {(OUT_TDATA_W - 1)'(0), hit};

endmodule

// File: src/cbct_checker.sv
// port-level checks for the collision test, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cbct_checker import cbct_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // a stalled response keeps its flag
  `CBCT_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "response changed while stalled")

  // nothing comes out of reset
  `CBCT_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !m_axis_tvalid_o, "response valid during reset")

  // input back-pressure only comes from a stalled output
  `CBCT_ASSERT(a_ready_cause, clk_i, rst_ni, !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i, "input stalled without output stall")

  // fill bits above the flag stay zero
  `CBCT_ASSERT(a_fill_zero, clk_i, rst_ni, m_axis_tvalid_o |-> m_axis_tdata_o[OUT_TDATA_W-1:1] == '0, "response fill bits set")

endmodule

bind circle_box_collision_test cbct_checker u_cbct_checker (.*);
